[sv/pfxcov_pkg.sv]
// ----------------------------------------------------------------------------
// pfxcov_pkg
// Shared types, codes and helpers of the IPv4 prefix cover table.
// ----------------------------------------------------------------------------
package pfxcov_pkg;

    localparam int ADDR_W            = 32;
    localparam int LEN_W             = 6;
    localparam int STATUS_W          = 3;
    localparam int EIDX_W            = 4;
    localparam int DEF_TABLE_ENTRIES = 16;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(32);

    // item command codes
    localparam logic CMD_APPEND = 1'b0;
    localparam logic CMD_CHECK  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_COVERED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic              command;
        logic [ADDR_W-1:0] net_address;
        logic [LEN_W-1:0]  prefix_len;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [EIDX_W-1:0]   entry_index;
    } out_item_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_WALK,
        CTL_FINISH
    } ctl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic walk;
        logic finish;
    } ctl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } dp_sts_t;

    // saturate a length to 32
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        return (len > MAX_LEN) ? MAX_LEN : len;
    endfunction

    // mask with the len most significant bits set, len 0..32
    function automatic logic [ADDR_W-1:0] lead_mask(input logic [LEN_W-1:0] len);
        return ~({ADDR_W{1'b1}} >> len);
    endfunction

endpackage

[sv/pfxcov_ctrl.sv]
// ----------------------------------------------------------------------------
// pfxcov_ctrl
// Sequencer of the prefix table: accepts a transaction, runs the table walk
// for check commands and hands the result to the output register.
// ----------------------------------------------------------------------------
module pfxcov_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_command,
    output logic                in_stall,
    input  pfxcov_pkg::dp_sts_t sts,
    output pfxcov_pkg::ctl_cmd_t cmd
);
    import pfxcov_pkg::*;

    ctl_state_t state_reg;
    ctl_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CTL_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (in_command == CMD_CHECK) ? CTL_WALK : CTL_FINISH;
                end
            end
            CTL_WALK:
            begin
                if (sts.walk_done)
                begin
                    state_next = CTL_FINISH;
                end
            end
            CTL_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default:
            begin
                state_next = CTL_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_stall   = 1'b1;
        cmd        = '0;
        case (state_reg)
            CTL_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            CTL_WALK:
            begin
                cmd.walk = 1'b1;
            end
            CTL_FINISH:
            begin
                cmd.finish = 1'b1;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[sv/pfxcov_dpath.sv]
// ----------------------------------------------------------------------------
// pfxcov_dpath
// Prefix table memory, entry counter, walk pipeline (read, then compare)
// and the output register.
// ----------------------------------------------------------------------------
module pfxcov_dpath #(
    parameter int TABLE_ENTRIES = pfxcov_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pfxcov_pkg::ctl_cmd_t  cmd,
    output pfxcov_pkg::dp_sts_t   sts,
    input  pfxcov_pkg::in_item_t  in_data,
    input  logic                  out_stall,
    output logic                  out_valid,
    output pfxcov_pkg::out_item_t out_data
);
    import pfxcov_pkg::*;

    localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

    // table storage
    logic [ADDR_W-1:0] mem_addr [TABLE_ENTRIES];
    logic [LEN_W-1:0]  mem_len  [TABLE_ENTRIES];

    // item and walk registers
    logic [ADDR_W-1:0]   addr_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic                cmp_vld_reg, cmp_vld_next;
    logic [IW-1:0]       cmp_idx_reg;
    logic [ADDR_W-1:0]   s_addr_reg;
    logic [LEN_W-1:0]    s_len_reg;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic [IW-1:0]       pend_idx_reg, pend_idx_next;
    logic                out_valid_reg, out_valid_next;
    out_item_t           out_data_reg;

    logic              issue;
    logic              shorter;
    logic              repl_hit;
    logic              cover_hit;
    logic              hit_now;
    logic              walk_done;
    logic              out_free;
    logic              wr_en;
    logic [IW-1:0]     wr_idx;
    logic [ADDR_W-1:0] wr_addr;
    logic [LEN_W-1:0]  wr_len;
    logic [LEN_W-1:0]  in_len;
    logic [IW+EIDX_W-1:0] idx_ext;

    assign in_len = clamp_len(in_data.prefix_len);

    // compare the entry read in the previous cycle
    assign shorter   = len_reg < s_len_reg;
    assign repl_hit  = shorter && ((s_addr_reg & lead_mask(len_reg)) == addr_reg);
    assign cover_hit = !shorter && ((addr_reg & lead_mask(s_len_reg)) == s_addr_reg);
    assign hit_now   = cmd.walk && cmp_vld_reg && (repl_hit || cover_hit);
    assign walk_done = cmd.walk && (hit_now || (rd_idx_reg >= count_reg));
    assign issue     = cmd.walk && !hit_now && (rd_idx_reg < count_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    assign sts = {walk_done, out_free};

    // walk control and pending result
    always_comb
    begin
        count_next       = count_reg;
        rd_idx_next      = rd_idx_reg;
        cmp_vld_next     = cmp_vld_reg;
        pend_status_next = pend_status_reg;
        pend_idx_next    = pend_idx_reg;
        wr_en            = 1'b0;
        wr_idx           = cmp_idx_reg;
        wr_addr          = addr_reg;
        wr_len           = len_reg;
        if (cmd.load)
        begin
            rd_idx_next      = '0;
            cmp_vld_next     = 1'b0;
            pend_status_next = ST_NONE;
            pend_idx_next    = '0;
            if (in_data.command == CMD_APPEND)
            begin
                if (count_reg < FULL_CNT)
                begin
                    wr_en            = 1'b1;
                    wr_idx           = count_reg[IW-1:0];
                    wr_addr          = in_data.net_address;
                    wr_len           = in_len;
                    count_next       = count_reg + CW'(1);
                    pend_status_next = ST_APPENDED;
                    pend_idx_next    = count_reg[IW-1:0];
                end
                else
                begin
                    pend_status_next = ST_FULL;
                end
            end
        end
        else if (cmd.walk)
        begin
            cmp_vld_next = issue;
            if (issue)
            begin
                rd_idx_next = rd_idx_reg + CW'(1);
            end
            if (hit_now)
            begin
                pend_idx_next = cmp_idx_reg;
                if (repl_hit)
                begin
                    wr_en            = 1'b1;
                    pend_status_next = ST_REPLACED;
                end
                else
                begin
                    pend_status_next = ST_COVERED;
                end
            end
        end
    end

    // output register next value
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish && out_free)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            rd_idx_reg    <= rd_idx_next;
            cmp_vld_reg   <= cmp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_status_reg <= pend_status_next;
        pend_idx_reg    <= pend_idx_next;
        if (cmd.load)
        begin
            addr_reg <= in_data.net_address;
            len_reg  <= in_len;
        end
        if (issue)
        begin
            cmp_idx_reg <= rd_idx_reg[IW-1:0];
        end
        if (cmd.finish && out_free)
        begin
            out_data_reg.status      <= pend_status_reg;
            out_data_reg.entry_index <= idx_ext[EIDX_W-1:0];
        end
    end

    assign idx_ext = {{EIDX_W{1'b0}}, pend_idx_reg};

    // table write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_addr[wr_idx] <= wr_addr;
            mem_len[wr_idx]  <= wr_len;
        end
    end

    // table read port, registered
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            s_addr_reg <= mem_addr[rd_idx_reg[IW-1:0]];
            s_len_reg  <= mem_len[rd_idx_reg[IW-1:0]];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[sv/ipv4_prefix_cover_table_top.sv]
// ----------------------------------------------------------------------------
// ipv4_prefix_cover_table_top
// Table of IPv4 prefixes with append and check-and-merge commands.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-----------------------------------
//  in      | input     | in_valid/in_stall  | command, net_address, prefix_len
//  out     | output    | out_valid/out_stall| status, entry_index
//
//  An append goes from acceptance through the finish state into the output register.
//  A check walks the stored entries until the output register is loaded:
//  one table read per cycle through the single read port, the compare in
//  the cycle after each read, the first hit ends it. The next transaction
//  is accepted in the cycle after the output register loads.
//  One transaction is in work at a time; the output register holds a result
//  while out_stall is high and the next transaction is accepted meanwhile.
//  Reset clears the entry count and all control state; table contents
//  are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
module ipv4_prefix_cover_table_top #(
    parameter int TABLE_ENTRIES = pfxcov_pkg::DEF_TABLE_ENTRIES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  pfxcov_pkg::in_item_t  in_data,
    output logic                  out_valid,
    input  logic                  out_stall,
    output pfxcov_pkg::out_item_t out_data
);
    import pfxcov_pkg::*;

    ctl_cmd_t ctl_cmd;
    dp_sts_t  dp_sts;

    // sequencer
    pfxcov_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_command (in_data.command),
        .in_stall   (in_stall),
        .sts        (dp_sts),
        .cmd        (ctl_cmd)
    );

    // table and walk datapath
    pfxcov_dpath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (ctl_cmd),
        .sts       (dp_sts),
        .in_data   (in_data),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    // at most one command at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl_cmd.load, ctl_cmd.walk, ctl_cmd.finish}))
        else $error("controller issued more than one command");

    // no transaction accepted during a walk or while finishing
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.walk || ctl_cmd.finish) |-> in_stall)
        else $error("input accepted while busy");

    // a finished result reaches the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        (ctl_cmd.finish && dp_sts.out_free) |=> out_valid)
        else $error("result lost at output register");

    // status stays within its code range
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status <= ST_FULL))
        else $error("illegal status code");

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the IPv4 prefix cover table. A scripted opening
// appends and checks prefixes at the length and address extremes. Random
// traffic follows: mostly checks aimed at stored prefixes, so that entries
// are both covered and replaced, plus appends up to and past a full table
// and unrelated noise. Every result is compared against a local model of
// the table or the script. Both channels see random idle cycles and stalls.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import pfxcov_pkg::*;

    localparam int N_ENTRIES    = DEF_TABLE_ENTRIES;
    localparam int RANDOM_ITEMS = 800;
    localparam int HEAD_ROWS    = 17;
    localparam int SCRIPT_ROWS  = 20;
    localparam int DRAIN_CYCLES = 40;
    localparam int TIMEOUT_NS   = 20_000_000;

    typedef struct packed {
        logic                command;
        logic [ADDR_W-1:0]   net_address;
        logic [LEN_W-1:0]    prefix_len;
        bit                  typed;
        logic [STATUS_W-1:0] want_status;
        logic [EIDX_W-1:0]   want_index;
    } script_row_t;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_item_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_item_t out_data;

    // local copy of the prefix table
    logic [ADDR_W-1:0] cover_addr [N_ENTRIES];
    logic [LEN_W-1:0]  cover_len  [N_ENTRIES];
    int unsigned       cover_count = 0;

    out_item_t   pending_results [$];
    int unsigned error_count = 0;
    bit          quiet_run   = 1'b0;
    int unsigned stall_left  = 0;

    // opening script; rows from HEAD_ROWS on run after the random traffic
    script_row_t script_rows [SCRIPT_ROWS] = '{
        '{CMD_CHECK,  32'hC0A8_0000, 6'd16, 1'b1, ST_NONE,     4'd0},
        '{CMD_APPEND, 32'hC0A8_0000, 6'd16, 1'b1, ST_APPENDED, 4'd0},
        '{CMD_APPEND, 32'h0A00_0000, 6'd8,  1'b1, ST_APPENDED, 4'd1},
        '{CMD_APPEND, 32'hFFFF_FFFF, 6'd32, 1'b1, ST_APPENDED, 4'd2},
        '{CMD_APPEND, 32'hAC10_0000, 6'd63, 1'b1, ST_APPENDED, 4'd3},
        '{CMD_APPEND, 32'h8000_0000, 6'd0,  1'b1, ST_APPENDED, 4'd4},
        '{CMD_CHECK,  32'hC0A8_1234, 6'd24, 1'b1, ST_COVERED,  4'd0},
        '{CMD_CHECK,  32'hFFFF_FFFF, 6'd40, 1'b1, ST_COVERED,  4'd2},
        '{CMD_CHECK,  32'hAC10_0000, 6'd33, 1'b1, ST_COVERED,  4'd3},
        '{CMD_CHECK,  32'h1234_5678, 6'd32, 1'b0, ST_NONE,     4'd0},
        '{CMD_CHECK,  32'hC000_0000, 6'd8,  1'b0, ST_NONE,     4'd0},
        '{CMD_CHECK,  32'h0A01_0203, 6'd0,  1'b0, ST_NONE,     4'd0},
        '{CMD_CHECK,  32'h0000_0000, 6'd32, 1'b0, ST_NONE,     4'd0},
        '{CMD_APPEND, 32'h0000_0000, 6'h3F, 1'b1, ST_APPENDED, 4'd5},
        '{CMD_CHECK,  32'h0000_0000, 6'd32, 1'b0, ST_NONE,     4'd0},
        '{CMD_CHECK,  32'h0A00_0000, 6'd4,  1'b0, ST_NONE,     4'd0},
        '{CMD_CHECK,  32'h0000_0000, 6'd4,  1'b0, ST_NONE,     4'd0},
        '{CMD_APPEND, 32'h5555_AAAA, 6'd24, 1'b1, ST_FULL,     4'd0},
        '{CMD_CHECK,  32'h0000_0000, 6'd0,  1'b0, ST_NONE,     4'd0},
        '{CMD_CHECK,  32'h1357_2468, 6'd20, 1'b0, ST_NONE,     4'd0}
    };

    ipv4_prefix_cover_table_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always #4 clk = ~clk;

    // leading ones mask of a prefix length 0..32
    function automatic logic [ADDR_W-1:0] prefix_mask(input int unsigned len);
        if (len == 0)
            return '0;
        return {ADDR_W{1'b1}} << (ADDR_W - len);
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // apply one transaction to the local table and return its answer
    function automatic out_item_t predict_cover(input in_item_t item);
        logic [LEN_W-1:0] len;
        out_item_t        res;
        bit               hit;
        len = (item.prefix_len > MAX_LEN) ? MAX_LEN : item.prefix_len;
        res.status      = ST_NONE;
        res.entry_index = '0;
        hit             = 1'b0;
        if (item.command == CMD_APPEND)
        begin
            if (cover_count < N_ENTRIES)
            begin
                cover_addr[cover_count] = item.net_address;
                cover_len[cover_count]  = len;
                res.status      = ST_APPENDED;
                res.entry_index = EIDX_W'(cover_count);
                cover_count++;
            end
            else
            begin
                res.status = ST_FULL;
            end
        end
        else
        begin
            // first hit in index order decides
            for (int i = 0; i < N_ENTRIES; i++)
            begin
                if (!hit && i < cover_count)
                begin
                    if (len < cover_len[i])
                    begin
                        if ((cover_addr[i] & prefix_mask(len)) == item.net_address)
                        begin
                            cover_addr[i]   = item.net_address;
                            cover_len[i]    = len;
                            res.status      = ST_REPLACED;
                            res.entry_index = EIDX_W'(i);
                            hit             = 1'b1;
                        end
                    end
                    else if ((item.net_address & prefix_mask(cover_len[i])) == cover_addr[i])
                    begin
                        res.status      = ST_COVERED;
                        res.entry_index = EIDX_W'(i);
                        hit             = 1'b1;
                    end
                end
            end
        end
        return res;
    endfunction

    // drive one transaction, wait for acceptance, queue its answer
    task automatic send_item(input in_item_t item, input bit typed, input out_item_t given);
        int unsigned gap;
        out_item_t   predicted;
        gap = quiet_run ? 0 : pick_gap();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (in_stall);
        predicted = predict_cover(item);
        pending_results.push_back(typed ? given : predicted);
        @(negedge clk);
    endtask

    // stimulus
    initial
    begin
        in_item_t          item;
        script_row_t       row;
        out_item_t         given;
        int unsigned       pick;
        int unsigned       j;
        int unsigned       len;
        int unsigned       low_len;
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] base_mask;

        // hold reset low, then release it
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // scripted opening
        for (int r = 0; r < HEAD_ROWS; r++)
        begin
            row = script_rows[r];
            item.command     = row.command;
            item.net_address = row.net_address;
            item.prefix_len  = row.prefix_len;
            given.status      = row.want_status;
            given.entry_index = row.want_index;
            send_item(item, row.typed, given);
        end

        // random traffic
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            quiet_run = (n >= 300 && n < 400);
            // hold off until the table has answered everything
            if (n == 200 || n == 550)
            begin
                in_valid <= 1'b0;
                do
                    @(negedge clk);
                while (pending_results.size() != 0);
            end

            item = '0;
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                item.command = CMD_APPEND;
                pick = $urandom_range(0, 99);
                if (pick < 70)
                begin
                    len  = $urandom_range(8, 32);
                    addr = $urandom & prefix_mask(len);
                end
                else if (pick < 85)
                begin
                    len  = $urandom_range(1, 32);
                    addr = $urandom;
                end
                else if (pick < 95)
                begin
                    len  = $urandom_range(33, 63);
                    addr = $urandom;
                end
                else
                begin
                    // zero length with host bits set: stored but never hits
                    len  = 0;
                    addr = $urandom | 32'h1;
                end
            end
            else
            begin
                item.command = CMD_CHECK;
                j    = (cover_count == 0) ? 0 : $urandom_range(0, cover_count - 1);
                pick = $urandom_range(0, 99);
                if (cover_count != 0 && pick < 25 && cover_len[j] > 8)
                begin
                    // shorter prefix of a stored entry: replace
                    low_len = (cover_len[j] > 12) ? cover_len[j] - 4 : 8;
                    len  = $urandom_range(low_len, cover_len[j] - 1);
                    addr = cover_addr[j] & prefix_mask(len);
                end
                else if (cover_count != 0 && pick < 75)
                begin
                    // inside a stored entry: covered
                    base_mask = prefix_mask(cover_len[j]);
                    addr = (cover_addr[j] & base_mask) | ($urandom & ~base_mask);
                    len  = (pick < 68) ? $urandom_range(cover_len[j], 32)
                                       : $urandom_range(33, 63);
                end
                else
                begin
                    addr = $urandom;
                    len  = $urandom_range(0, 63);
                end
            end
            item.net_address = addr;
            item.prefix_len  = LEN_W'(len);
            given = '0;
            send_item(item, 1'b0, given);
        end
        quiet_run = 1'b0;

        // closing rows: full table and zero length against zero address
        for (int r = HEAD_ROWS; r < SCRIPT_ROWS; r++)
        begin
            row = script_rows[r];
            item.command     = row.command;
            item.net_address = row.net_address;
            item.prefix_len  = row.prefix_len;
            given.status      = row.want_status;
            given.entry_index = row.want_index;
            send_item(item, row.typed, given);
        end
        in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("ipv4_prefix_cover_table_top regression: pass");
        else
            $display("ipv4_prefix_cover_table_top regression: fail");
        $finish;
    end

    // receiver stall: random bursts, none in quiet stretches
    always @(negedge clk)
    begin
        if (!rst_n || quiet_run)
        begin
            stall_left = 0;
            out_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_left = pick_gap();
            out_stall <= (stall_left != 0);
            if (stall_left != 0)
                stall_left--;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual status %0d index %0d",
                         $time, out_data.status, out_data.entry_index);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                begin
                    error_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, out_data.status);
                end
                if (out_data.entry_index !== want.entry_index)
                begin
                    error_count++;
                    $display("%0t: entry_index mismatch, expected %0d, actual %0d",
                             $time, want.entry_index, out_data.entry_index);
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("ipv4_prefix_cover_table_top regression: fail");
        $finish;
    end

endmodule

[sim.f]
sv/pfxcov_pkg.sv
sv/pfxcov_ctrl.sv
sv/pfxcov_dpath.sv
sv/ipv4_prefix_cover_table_top.sv
sim/testbench.sv
